### design/assert_macros.svh
// Assertion helpers shared by the deframer RTL.
// Simulation gets the checks; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// a at an edge requires b at that same edge
`define SAP_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// a at an edge requires b at the next edge
`define SAP_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`else

`define SAP_ASSERT_IMPLIES(label, clk, rst, a, b)
`define SAP_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

### design/sap_df_pkg.sv
`timescale 1ns / 1ps

package sap_df_pkg;

  // byte roles as seen on the output word
  localparam logic [2:0] ROLE_MSG_ID    = 3'd0;
  localparam logic [2:0] ROLE_PCOUNT    = 3'd1;
  localparam logic [2:0] ROLE_MSG_RSV   = 3'd2;
  localparam logic [2:0] ROLE_PAR_ID    = 3'd3;
  localparam logic [2:0] ROLE_PAR_RSV   = 3'd4;
  localparam logic [2:0] ROLE_LEN       = 3'd5;
  localparam logic [2:0] ROLE_VALUE     = 3'd6;
  localparam logic [2:0] ROLE_PAD       = 3'd7;

  // header byte positions
  localparam logic [1:0] HDR_POS_FIRST  = 2'd0;
  localparam logic [1:0] HDR_POS_SECOND = 2'd1;
  localparam logic [1:0] HDR_POS_THIRD  = 2'd2;
  localparam logic [1:0] HDR_POS_LAST   = 2'd3;

  typedef enum logic [3:0] {
    PH_MSG_HDR = 4'b0001,
    PH_PAR_HDR = 4'b0010,
    PH_VALUE   = 4'b0100,
    PH_PAD     = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  header_position;
    logic [7:0]  params_left;
    logic [15:0] bytes_left;
    logic [1:0]  pad_left;
    logic [7:0]  current_message;
    logic [7:0]  current_parameter;
    logic [7:0]  length_high;
    logic [15:0] value_position;
  } sap_df_state_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  message_id;
    logic [7:0]  parameter_id;
    logic [7:0]  value_byte;
    logic [15:0] value_offset;
    logic        value_last;
    logic        message_done;
    logic        incomplete;
  } sap_df_result_t;

endpackage

### design/sap_df_in_if.sv
`timescale 1ns / 1ps

interface sap_df_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

### design/sap_df_out_if.sv
`timescale 1ns / 1ps

interface sap_df_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [7:0]  message_id;
  logic [7:0]  parameter_id;
  logic [7:0]  value_byte;
  logic [15:0] value_offset;
  logic        value_last;
  logic        message_done;
  logic        incomplete;

  modport source (
    output valid, output byte_role, output message_id, output parameter_id,
    output value_byte, output value_offset, output value_last,
    output message_done, output incomplete, input ready
  );
  modport sink (
    input valid, input byte_role, input message_id, input parameter_id,
    input value_byte, input value_offset, input value_last,
    input message_done, input incomplete, output ready
  );
endinterface

### design/sap_df_step.sv
`timescale 1ns / 1ps

// Per-byte parse step: current state plus one byte gives the tagged word
// and the next state.
module sap_df_step
  import sap_df_pkg::*;
(
  input  sap_df_state_t  st,
  input  logic [7:0]     data_byte,
  input  logic           end_of_buffer,
  output sap_df_state_t  st_next,
  output sap_df_result_t res
);

  logic [15:0] len;
  logic [15:0] bytes_dec;
  logic [1:0]  pad_dec;
  logic [7:0]  params_dec;
  logic        fin;
  logic        done;
  logic [2:0]  role;
  logic [7:0]  pid;
  logic [15:0] offset;
  logic        last;

  assign len        = {st.length_high, data_byte};
  assign bytes_dec  = st.bytes_left - 16'd1;
  assign pad_dec    = st.pad_left - 2'd1;
  assign params_dec = st.params_left - 8'd1;

  always_comb begin
    st_next = st;
    fin     = 1'b0;
    done    = 1'b0;
    role    = ROLE_PAD;
    pid     = st.current_parameter;
    offset  = '0;
    last    = 1'b0;

    case (st.phase)
      PH_MSG_HDR: begin
        pid = '0;
        case (st.header_position)
          HDR_POS_FIRST: begin
            role = ROLE_MSG_ID;
            st_next.current_message = data_byte;
          end
          HDR_POS_SECOND: begin
            role = ROLE_PCOUNT;
            st_next.params_left = data_byte;
          end
          default: role = ROLE_MSG_RSV;
        endcase
        if (st.header_position == HDR_POS_LAST) begin
          st_next.header_position = HDR_POS_FIRST;
          if (st.params_left == 8'd0) begin
            done = 1'b1;
          end else begin
            st_next.phase = PH_PAR_HDR;
          end
        end else begin
          st_next.header_position = st.header_position + 2'd1;
        end
      end
      PH_PAR_HDR: begin
        case (st.header_position)
          HDR_POS_FIRST: begin
            role = ROLE_PAR_ID;
            st_next.current_parameter = data_byte;
            pid = data_byte;
          end
          HDR_POS_SECOND: role = ROLE_PAR_RSV;
          HDR_POS_THIRD: begin
            role = ROLE_LEN;
            st_next.length_high = data_byte;
          end
          default: role = ROLE_LEN;
        endcase
        if (st.header_position == HDR_POS_LAST) begin
          st_next.header_position = HDR_POS_FIRST;
          st_next.value_position  = '0;
          st_next.bytes_left      = len;
          st_next.pad_left        = 2'(3'd4 - {1'b0, len[1:0]});
          if (len == 16'd0) begin
            fin = 1'b1;
          end else begin
            st_next.phase = PH_VALUE;
          end
        end else begin
          st_next.header_position = st.header_position + 2'd1;
        end
      end
      PH_VALUE: begin
        role = ROLE_VALUE;
        offset = st.value_position;
        st_next.value_position = st.value_position + 16'd1;
        st_next.bytes_left = bytes_dec;
        if (bytes_dec == 16'd0) begin
          last = 1'b1;
          if (st.pad_left != 2'd0) begin
            st_next.phase = PH_PAD;
          end else begin
            fin = 1'b1;
          end
        end
      end
      PH_PAD: begin
        role = ROLE_PAD;
        st_next.pad_left = pad_dec;
        if (pad_dec == 2'd0) begin
          fin = 1'b1;
        end
      end
      default: begin
        st_next.phase = PH_MSG_HDR;
        st_next.header_position = HDR_POS_FIRST;
      end
    endcase

    // parameter consumed: the message ends when it was the last one
    if (fin) begin
      st_next.params_left = params_dec;
      st_next.header_position = HDR_POS_FIRST;
      if (params_dec == 8'd0) begin
        st_next.phase = PH_MSG_HDR;
        done = 1'b1;
      end else begin
        st_next.phase = PH_PAR_HDR;
      end
    end

    // buffer ran out mid-message: drop it, restart at a message header
    if (end_of_buffer && !done) begin
      st_next.phase           = PH_MSG_HDR;
      st_next.header_position = HDR_POS_FIRST;
      st_next.params_left     = '0;
      st_next.bytes_left      = '0;
      st_next.pad_left        = '0;
      st_next.value_position  = '0;
    end

    res.byte_role    = role;
    res.message_id   = st_next.current_message;
    res.parameter_id = pid;
    res.value_byte   = data_byte;
    res.value_offset = offset;
    res.value_last   = last;
    res.message_done = done;
    res.incomplete   = end_of_buffer && !done;
  end

endmodule

### design/sap_message_deframer_core.sv
// An accepted word is registered into the result register, or into the skid while
// the result register is stalled, and reaches tx from there. One byte per cycle while
// the skid is empty; the parse step is a single short combinational pass from parse
// state and input byte into the output stage. The two-entry output stage (result
// register plus skid) keeps rx.ready registered. Reset (rst, synchronous, active
// high) returns the parser to a message header and empties both output entries.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sap_message_deframer_core
  import sap_df_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  sap_df_in_if.sink    rx,
  sap_df_out_if.source tx
);

  // Parse state, advanced once for every accepted input word.
  sap_df_state_t  st;
  sap_df_state_t  st_next;
  sap_df_result_t step_res;

  // Output stage: head register drives tx, skid catches a word accepted
  // while the head is stalled.
  sap_df_result_t out_word;
  sap_df_result_t skid_word;
  logic           out_valid;
  logic           skid_valid;
  logic           accept;
  logic           head_free;

  // Check helpers
  logic           eob_accept;
  logic           parse_idle;

  sap_df_step u_step (
    .st            (st),
    .data_byte     (rx.data_byte),
    .end_of_buffer (rx.end_of_buffer),
    .st_next       (st_next),
    .res           (step_res)
  );

  // Ready only depends on the skid being empty, so no combinational path
  // from tx.ready back to rx.ready.
  assign rx.ready  = !skid_valid;
  assign accept    = rx.valid && rx.ready;
  assign head_free = !out_valid || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase             <= PH_MSG_HDR;
      st.header_position   <= HDR_POS_FIRST;
      st.params_left       <= '0;
      st.bytes_left        <= '0;
      st.pad_left          <= '0;
      st.current_message   <= '0;
      st.current_parameter <= '0;
      st.length_high       <= '0;
      st.value_position    <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Valid flags: control, so reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_free) begin
      // skid drains first; it can only be full when no accept happened
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (accept) begin
        out_word <= step_res;
      end
    end else if (accept) begin
      skid_word <= step_res;
    end
  end

  assign tx.valid        = out_valid;
  assign tx.byte_role    = out_word.byte_role;
  assign tx.message_id   = out_word.message_id;
  assign tx.parameter_id = out_word.parameter_id;
  assign tx.value_byte   = out_word.value_byte;
  assign tx.value_offset = out_word.value_offset;
  assign tx.value_last   = out_word.value_last;
  assign tx.message_done = out_word.message_done;
  assign tx.incomplete   = out_word.incomplete;

  assign eob_accept = accept && rx.end_of_buffer;
  assign parse_idle = (st.phase == PH_MSG_HDR) && (st.header_position == HDR_POS_FIRST);

  // A full skid always sits behind a full head register.
  `SAP_ASSERT_IMPLIES(a_skid_behind_head, clk, rst, skid_valid, out_valid)

  // Value-last only ever marks a value byte.
  `SAP_ASSERT_IMPLIES(a_last_is_value, clk, rst, tx.valid && tx.value_last, tx.byte_role == ROLE_VALUE)

  // A word never both completes and drops a message.
  `SAP_ASSERT_IMPLIES(a_done_not_dropped, clk, rst, tx.valid && tx.message_done, !tx.incomplete)

  // After the last byte of a buffer the parser waits at a fresh message header.
  `SAP_ASSERT_NEXT(a_eob_restarts, clk, rst, eob_accept, parse_idle)

endmodule
